### rtl/core/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants for the circular list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_VALUE = 3'd5,
    CMD_READOUT   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_NODE,
    S_LINK_FIX,
    S_DEL_FRONT,
    S_WALK
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] elem;
    logic               last;
    logic [6:0]         count;
  } result_t;

  // take: pop a node index from the pool, give: return one
  typedef struct packed {
    logic take;
    logic give;
  } pool_ctl_t;

endpackage

`default_nettype wire

### rtl/core/clm_pool.sv
// ----------------------------------------------------------------------------
// clm_pool
// Free node pool: a stack of returned indices plus a counter of never-used
// indices, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_pool #(
  parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire clm_pkg::pool_ctl_t          ctl,
  input  wire logic [$clog2(CAPACITY)-1:0] give_idx,
  output logic      [$clog2(CAPACITY)-1:0] idx
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] stack_mem [CAPACITY];
  logic [IW-1:0] top_q;
  logic [CW-1:0] sp;
  logic [CW-1:0] fresh;
  logic [CW-1:0] sp_m1;

  assign sp_m1 = sp - CW'(1);

  // top entry is re-read every cycle; it is registered, so it is valid in the cycle after sp settles
  always_ff @(posedge clk) begin
    if (ctl.give) begin
      stack_mem[sp[IW-1:0]] <= give_idx;
    end
    top_q <= stack_mem[sp_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      fresh <= '0;
    end else if (ctl.give) begin
      sp <= sp + CW'(1);
    end else if (ctl.take) begin
      if (sp != '0) begin
        sp <= sp_m1;
      end else begin
        fresh <= fresh + CW'(1);
      end
    end
  end

  assign idx = (sp != '0) ? top_q : fresh[IW-1:0];

endmodule

`default_nettype wire

### rtl/core/circular_list_manager_top.sv
// ----------------------------------------------------------------------------
// circular_list_manager_top
// Bounded circular singly linked list of signed values in a node memory.
//
//   channel | signals               | beat
//   --------+-----------------------+-------------------------------------
//   command | start, busy, item     | taken when start is high, busy low
//   result  | strobe, result        | one-cycle strobe per beat, cannot be held
//
// Insert front/back steps through S_INS_NODE then S_LINK_FIX; delete front
// through S_DEL_FRONT. Insert after key, delete back, delete by value and
// readout walk in S_WALK, one node memory read per cycle, and readout
// emits one beat per element. Full/empty/no-op answers come the cycle after
// accept with busy never raised. Reset clears list state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_manager_top #(
  parameter int CAPACITY   = clm_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = clm_pkg::DATA_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire clm_pkg::item_t  item,
  output logic                 busy,
  output logic                 strobe,
  output clm_pkg::result_t     result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // node memory
  logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic [IW-1:0]         link_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] val_q;
  logic [IW-1:0]         link_q;
  logic [IW-1:0]         rd_addr;
  logic                  val_we;
  logic [IW-1:0]         val_wa;
  logic [DATA_WIDTH-1:0] val_wd;
  logic                  link_we;
  logic [IW-1:0]         link_wa;
  logic [IW-1:0]         link_wd;

  clm_pkg::state_e       state, state_next;
  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [2:0]            cmd_r, cmd_next;
  logic [DATA_WIDTH-1:0] val_r, val_next;
  logic [DATA_WIDTH-1:0] key_r, key_next;
  logic [IW-1:0]         cur, cur_next;
  logic [IW-1:0]         prev, prev_next;
  logic [CW-1:0]         idx_r, idx_next;
  logic                  hit_head, hit_next;
  logic [IW-1:0]         head_nx, hnx_next;
  logic [IW-1:0]         p_r, p_next;
  logic [IW-1:0]         n_r, n_next;

  clm_pkg::pool_ctl_t    pool_ctl;
  logic [IW-1:0]         give_idx;
  logic [IW-1:0]         pool_idx;

  logic                  emit;
  clm_pkg::status_e      st;
  logic signed [31:0]    el;
  logic                  lst;

  logic signed [63:0]    val_wide, key_wide, elem_wide;
  logic                  empty, full, match, last_node;

  assign val_wide  = 64'(item.value);
  assign key_wide  = 64'(item.key);
  assign elem_wide = 64'($signed(val_q));
  assign empty     = (cnt == '0);
  assign full      = (cnt == CW'(CAPACITY));
  assign match     = (val_q == key_r);
  assign last_node = (idx_r == cnt - CW'(1));
  assign busy      = (state != clm_pkg::S_IDLE);

  clm_pool #(.CAPACITY(CAPACITY)) u_pool (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pool_ctl),
    .give_idx (give_idx),
    .idx      (pool_idx)
  );

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    val_q  <= val_mem[rd_addr];
    link_q <= link_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    cnt_next   = cnt;
    cmd_next   = cmd_r;
    val_next   = val_r;
    key_next   = key_r;
    cur_next   = cur;
    prev_next  = prev;
    idx_next   = idx_r;
    hit_next   = hit_head;
    hnx_next   = head_nx;
    p_next     = p_r;
    n_next     = n_r;
    rd_addr    = head;
    val_we     = 1'b0;
    val_wa     = pool_idx;
    val_wd     = val_r;
    link_we    = 1'b0;
    link_wa    = cur;
    link_wd    = link_q;
    pool_ctl   = '0;
    give_idx   = head;
    emit       = 1'b0;
    st         = clm_pkg::ST_OK;
    el         = '0;
    lst        = 1'b1;

    unique case (state)
      clm_pkg::S_IDLE: begin
        // head is read while idle, so its node is in hand on the first step
        if (start) begin
          cmd_next  = item.cmd;
          val_next  = val_wide[DATA_WIDTH-1:0];
          key_next  = key_wide[DATA_WIDTH-1:0];
          cur_next  = head;
          prev_next = tail;
          idx_next  = '0;
          hit_next  = 1'b0;
          case (item.cmd) inside
            clm_pkg::CMD_INS_FRONT, clm_pkg::CMD_INS_BACK: begin
              if (full) begin
                emit = 1'b1;
                st   = clm_pkg::ST_FULL;
              end else begin
                state_next = clm_pkg::S_INS_NODE;
              end
            end
            clm_pkg::CMD_INS_AFTER: begin
              if (empty) begin
                emit = 1'b1;
                st   = clm_pkg::ST_EMPTY;
              end else if (full) begin
                emit = 1'b1;
                st   = clm_pkg::ST_FULL;
              end else begin
                state_next = clm_pkg::S_WALK;
              end
            end
            clm_pkg::CMD_DEL_FRONT: begin
              if (empty) begin
                emit = 1'b1;
                st   = clm_pkg::ST_EMPTY;
              end else begin
                state_next = clm_pkg::S_DEL_FRONT;
              end
            end
            clm_pkg::CMD_DEL_BACK, clm_pkg::CMD_DEL_VALUE, clm_pkg::CMD_READOUT: begin
              if (empty) begin
                emit = 1'b1;
                st   = clm_pkg::ST_EMPTY;
              end else begin
                state_next = clm_pkg::S_WALK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      clm_pkg::S_INS_NODE: begin
        val_we         = 1'b1;
        link_we        = 1'b1;
        link_wa        = pool_idx;
        link_wd        = empty ? pool_idx : head;
        pool_ctl.take  = 1'b1;
        n_next         = pool_idx;
        p_next         = empty ? pool_idx : tail;
        state_next     = clm_pkg::S_LINK_FIX;
      end

      clm_pkg::S_LINK_FIX: begin
        link_we  = 1'b1;
        link_wa  = p_r;
        link_wd  = n_r;
        cnt_next = cnt + CW'(1);
        if (cmd_r == clm_pkg::CMD_INS_FRONT) begin
          head_next = n_r;
          if (empty) begin
            tail_next = n_r;
          end
        end else if (cmd_r == clm_pkg::CMD_INS_BACK) begin
          tail_next = n_r;
          if (empty) begin
            head_next = n_r;
          end
        end else if (p_r == tail) begin
          tail_next = n_r;
        end
        emit       = 1'b1;
        state_next = clm_pkg::S_IDLE;
      end

      clm_pkg::S_DEL_FRONT: begin
        link_we       = 1'b1;
        link_wa       = tail;
        head_next     = link_q;
        pool_ctl.give = 1'b1;
        cnt_next      = cnt - CW'(1);
        emit          = 1'b1;
        state_next    = clm_pkg::S_IDLE;
      end

      clm_pkg::S_WALK: begin
        // step to the next node by default; ignored once the walk ends
        rd_addr   = link_q;
        cur_next  = link_q;
        prev_next = cur;
        idx_next  = idx_r + CW'(1);
        case (cmd_r) inside
          clm_pkg::CMD_INS_AFTER: begin
            if (match) begin
              val_we        = 1'b1;
              link_we       = 1'b1;
              link_wa       = pool_idx;
              pool_ctl.take = 1'b1;
              n_next        = pool_idx;
              p_next        = cur;
              state_next    = clm_pkg::S_LINK_FIX;
            end else if (last_node) begin
              emit       = 1'b1;
              st         = clm_pkg::ST_NOT_FOUND;
              state_next = clm_pkg::S_IDLE;
            end
          end
          clm_pkg::CMD_DEL_BACK: begin
            if (link_q == tail) begin
              link_we       = 1'b1;
              link_wd       = head;
              tail_next     = cur;
              pool_ctl.give = 1'b1;
              give_idx      = tail;
              cnt_next      = cnt - CW'(1);
              emit          = 1'b1;
              state_next    = clm_pkg::S_IDLE;
            end
          end
          clm_pkg::CMD_DEL_VALUE: begin
            // head is visited first but only taken when nothing else matches
            if (idx_r == '0) begin
              hit_next = match;
              hnx_next = link_q;
            end
            if (match && idx_r != '0) begin
              link_we       = 1'b1;
              link_wa       = prev;
              if (cur == tail) begin
                tail_next = prev;
              end
              pool_ctl.give = 1'b1;
              give_idx      = cur;
              cnt_next      = cnt - CW'(1);
              emit          = 1'b1;
              state_next    = clm_pkg::S_IDLE;
            end else if (last_node) begin
              if (hit_head || (idx_r == '0 && match)) begin
                link_we       = 1'b1;
                link_wa       = tail;
                link_wd       = (idx_r == '0) ? link_q : head_nx;
                head_next     = link_wd;
                pool_ctl.give = 1'b1;
                cnt_next      = cnt - CW'(1);
              end else begin
                st = clm_pkg::ST_NOT_FOUND;
              end
              emit       = 1'b1;
              state_next = clm_pkg::S_IDLE;
            end
          end
          clm_pkg::CMD_READOUT: begin
            emit = 1'b1;
            el   = elem_wide[31:0];
            lst  = last_node;
            if (last_node) begin
              state_next = clm_pkg::S_IDLE;
            end
          end
          default: begin
            state_next = clm_pkg::S_IDLE;
          end
        endcase
      end

      default: begin
        state_next = clm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= clm_pkg::S_IDLE;
      head   <= '0;
      tail   <= '0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      cnt    <= cnt_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_next;
    val_r    <= val_next;
    key_r    <= key_next;
    cur      <= cur_next;
    prev     <= prev_next;
    idx_r    <= idx_next;
    hit_head <= hit_next;
    head_nx  <= hnx_next;
    p_r      <= p_next;
    n_r      <= n_next;
    if (emit) begin
      result.status <= st;
      result.elem   <= el;
      result.last   <= lst;
      result.count  <= 7'(cnt_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> !busy)
    else $error("final beat while still busy");

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (strobe || busy))
    else $error("accepted command neither answered nor in progress");

  a_pool_excl: assert property (@(posedge clk) disable iff (rst)
    !(pool_ctl.take && pool_ctl.give))
    else $error("pool take and give in one cycle");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives list commands into the circular list manager and checks every result
// beat against a behavioural list model kept as an ordered queue of values.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clm_pkg::*;

  localparam int CAP = 64;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  circular_list_manager_top u_top (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  // list contents head to tail; node numbering is invisible from outside
  logic signed [31:0] list_q[$];
  item_t              pending_q[$];
  result_t            expected_q[$];
  int                 errors;
  int                 burst_left;
  int                 gap_left;
  bit                 hold_for_drain;

  function automatic result_t mk_res(status_e st, logic signed [31:0] e, logic l);
    result_t r;
    r.status = st;
    r.elem   = e;
    r.last   = l;
    r.count  = 7'(list_q.size());
    return r;
  endfunction

  task automatic predict_list_cmd(input item_t it);
    int idx;
    int n;
    idx = -1;
    n = list_q.size();
    case (it.cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (n >= CAP) expected_q.push_back(mk_res(ST_FULL, 0, 1'b1));
        else begin
          if (it.cmd == CMD_INS_FRONT) list_q.push_front(it.value);
          else list_q.push_back(it.value);
          expected_q.push_back(mk_res(ST_OK, 0, 1'b1));
        end
      end
      CMD_INS_AFTER: begin
        if (n == 0) expected_q.push_back(mk_res(ST_EMPTY, 0, 1'b1));
        else if (n >= CAP) expected_q.push_back(mk_res(ST_FULL, 0, 1'b1));
        else begin
          for (int i = 0; i < n; i++)
            if (idx < 0 && list_q[i] == it.key) idx = i;
          if (idx < 0) expected_q.push_back(mk_res(ST_NOT_FOUND, 0, 1'b1));
          else begin
            list_q.insert(idx + 1, it.value);
            expected_q.push_back(mk_res(ST_OK, 0, 1'b1));
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (n == 0) expected_q.push_back(mk_res(ST_EMPTY, 0, 1'b1));
        else begin
          if (it.cmd == CMD_DEL_FRONT) void'(list_q.pop_front());
          else void'(list_q.pop_back());
          expected_q.push_back(mk_res(ST_OK, 0, 1'b1));
        end
      end
      CMD_DEL_VALUE: begin
        if (n == 0) expected_q.push_back(mk_res(ST_EMPTY, 0, 1'b1));
        else begin
          // second node onwards first, head last
          for (int i = 1; i < n; i++)
            if (idx < 0 && list_q[i] == it.key) idx = i;
          if (idx < 0 && list_q[0] == it.key) idx = 0;
          if (idx < 0) expected_q.push_back(mk_res(ST_NOT_FOUND, 0, 1'b1));
          else begin
            list_q.delete(idx);
            expected_q.push_back(mk_res(ST_OK, 0, 1'b1));
          end
        end
      end
      CMD_READOUT: begin
        if (n == 0) expected_q.push_back(mk_res(ST_EMPTY, 0, 1'b1));
        else
          for (int i = 0; i < n; i++)
            expected_q.push_back(mk_res(ST_OK, list_q[i], 1'(i == n - 1)));
      end
      default: expected_q.push_back(mk_res(ST_OK, 0, 1'b1));
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: bursts with random gaps, optional hold until drained
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (start && busy) begin
      // held until taken
    end else begin
      if (start) predict_list_cmd(item);
      // while holding, nothing new goes out until every result is back
      if (hold_for_drain && (expected_q.size() != 0 || start)) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        item  <= pending_q.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat status=%0d elem=%0d", result.status, result.elem);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, result.status);
          errors++;
        end
        if (result.elem !== exp_r.elem) begin
          $error("elem: expected %0d, got %0d", exp_r.elem, result.elem);
          errors++;
        end
        if (result.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, result.last);
          errors++;
        end
        if (result.count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, result.count);
          errors++;
        end
      end
    end
  end

  function automatic item_t mk_item(cmd_e c, logic signed [31:0] v, logic signed [31:0] k);
    item_t it;
    it.cmd = c;
    it.value = v;
    it.key = k;
    return it;
  endfunction

  // key drawn from a small pool so that searches often hit
  function automatic logic signed [31:0] pick_val();
    return ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 15));
  endfunction

  // sampled away from the driving edge so that everything has settled
  task automatic wait_drained();
    while (pending_q.size() != 0 || start || expected_q.size() != 0 || busy)
      @(negedge clk);
  endtask

  initial begin
    int c;
    errors = 0;
    hold_for_drain = 1'b0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, unused code, fill to full
    pending_q.push_back(mk_item(CMD_DEL_FRONT, 0, 0));
    pending_q.push_back(mk_item(CMD_DEL_BACK, 0, 0));
    pending_q.push_back(mk_item(CMD_DEL_VALUE, 0, 0));
    pending_q.push_back(mk_item(CMD_INS_AFTER, 1, 1));
    pending_q.push_back(mk_item(CMD_READOUT, 0, 0));
    pending_q.push_back(mk_item(CMD_INS_FRONT, 32'sh7fffffff, 32'shffffffff));
    pending_q.push_back(mk_item(CMD_INS_BACK, 32'sh80000000, 0));
    pending_q.push_back(mk_item(CMD_INS_AFTER, -1, 32'sh80000000));
    pending_q.push_back(mk_item(CMD_INS_AFTER, 5, 32'sh7fffffff));
    pending_q.push_back(mk_item(CMD_INS_AFTER, 5, 12345));
    pending_q.push_back(mk_item(CMD_READOUT, 0, 0));
    pending_q.push_back(mk_item(CMD_INS_FRONT, 5, 0));
    pending_q.push_back(mk_item(CMD_DEL_VALUE, 0, 5));
    pending_q.push_back(mk_item(CMD_DEL_VALUE, 0, 32'sh80000000));
    pending_q.push_back(mk_item(CMD_DEL_VALUE, 0, 999));
    pending_q.push_back(mk_item(CMD_DEL_BACK, 0, 0));
    pending_q.push_back(mk_item(CMD_DEL_FRONT, 0, 0));
    pending_q.push_back(mk_item(cmd_e'(3'd7), 32'shffffffff, 32'shffffffff));
    pending_q.push_back(mk_item(CMD_READOUT, 0, 0));
    for (int i = 0; i < CAP; i++) pending_q.push_back(mk_item(CMD_INS_BACK, i, 0));
    pending_q.push_back(mk_item(CMD_INS_FRONT, 1, 0));
    pending_q.push_back(mk_item(CMD_INS_AFTER, 1, 3));
    pending_q.push_back(mk_item(CMD_READOUT, 0, 0));

    // sender waits for everything outstanding before going on
    hold_for_drain = 1'b1;
    wait_drained();
    hold_for_drain = 1'b0;

    for (int i = 0; i < CAP; i++) pending_q.push_back(mk_item(CMD_DEL_BACK, 0, 0));

    for (int i = 0; i < 230; i++) begin
      c = $urandom_range(0, 99);
      if (c < 22)      pending_q.push_back(mk_item(CMD_INS_FRONT, pick_val(), pick_val()));
      else if (c < 46) pending_q.push_back(mk_item(CMD_INS_BACK, pick_val(), pick_val()));
      else if (c < 60) pending_q.push_back(mk_item(CMD_INS_AFTER, pick_val(), pick_val()));
      else if (c < 68) pending_q.push_back(mk_item(CMD_DEL_FRONT, pick_val(), pick_val()));
      else if (c < 76) pending_q.push_back(mk_item(CMD_DEL_BACK, pick_val(), pick_val()));
      else if (c < 90) pending_q.push_back(mk_item(CMD_DEL_VALUE, pick_val(), pick_val()));
      else if (c < 98) pending_q.push_back(mk_item(CMD_READOUT, pick_val(), pick_val()));
      else             pending_q.push_back(mk_item(cmd_e'(3'd7), pick_val(), pick_val()));
    end

    wait_drained();
    repeat (CAP + 8) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
